/* rtl/spirv_extension_import_scanner_core_defines.svh */
// ----------------------------------------------------------------------------
// spirv extension import scanner assertion macros
// shared concurrent assertion forms for the scanner checker
// ----------------------------------------------------------------------------
`ifndef SPIRV_EXTENSION_IMPORT_SCANNER_CORE_DEFINES_SVH
`define SPIRV_EXTENSION_IMPORT_SCANNER_CORE_DEFINES_SVH

// checked on every rising edge outside reset
`define SPVIMP_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// checked on every rising edge, reset included
`define SPVIMP_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

/* rtl/spvimp_pkg.sv */
// ----------------------------------------------------------------------------
// spirv extension import scanner package
// constants, status codes and helpers shared by the scanner files
// ----------------------------------------------------------------------------
package spvimp_pkg;

  localparam logic [31:0] SpvMagic       = 32'h0723_0203;
  localparam logic [15:0] OpExtInstImport = 16'd11;
  localparam logic [2:0]  HeaderWords    = 3'd5;
  localparam logic [15:0] MinImportCount = 16'd5;
  localparam logic [2:0]  PosSaturate    = 3'd5;

  // "NonSemantic." as little-endian words
  localparam logic [31:0] NameWord0 = 32'h536E_6F4E;
  localparam logic [31:0] NameWord1 = 32'h6E61_6D65;
  localparam logic [31:0] NameWord2 = 32'h2E63_6974;

  typedef enum logic [1:0] {
    STATUS_ACCEPTED  = 2'd0,
    STATUS_NOT_SPIRV = 2'd1,
    STATUS_NEEDS_EXT = 2'd2
  } status_e;

  typedef struct packed {
    logic    uses_extension;
    status_e status;
  } result_t;

  function automatic logic [31:0] expected_name_word(input logic [2:0] pos);
    logic [31:0] w;
    case (pos)
      3'd2:    w = NameWord0;
      3'd3:    w = NameWord1;
      default: w = NameWord2;
    endcase
    return w;
  endfunction

endpackage

/* rtl/spirv_extension_import_scanner_core.sv */
// ----------------------------------------------------------------------------
// spirv extension import scanner core
// walks a spir-v word stream, flags non-spir-v input and reports whether a
// non-semantic import needs an extension the device lacks
// ----------------------------------------------------------------------------
// channel   dir  tdata bits                          tlast
// s_axis    in   [31:0] module_word                  last_word
// m_axis    out  [1:0] status, [2] uses_extension    -
// cfg       in   cfg_wdata_i extension_supported     -
//
// one word per cycle while s_axis_tready is high; the scan state updates
// in the cycle a word is taken; the result appears in the cycle after the
// last word is taken and is held in an output register until taken; a
// new word is taken while it waits unless the output register is full and
// stalled; reset clears scan state, the config register and output valid
// ----------------------------------------------------------------------------
module spirv_extension_import_scanner_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic        cfg_wdata_i,    // [0] extension_supported
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // [31:0] module_word
  input  logic        s_axis_tlast,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata    // [1:0] status, [2] uses_extension
);
  import spvimp_pkg::*;

  logic        ext_sup_q;
  logic [2:0]  hdr_idx_q, hdr_idx_d;
  logic        magic_q, magic_d;
  logic [15:0] words_left_q, words_left_d;
  logic [2:0]  pos_q, pos_d;
  logic        cand_q, cand_d;
  logic        match_q, match_d;
  logic        stopped_q, stopped_d;
  logic        out_valid_q, out_valid_d;
  result_t     out_res_q, out_res_d;

  logic        in_acc;
  logic        long_enough;
  logic [15:0] count;
  logic [15:0] wl_dec;
  logic        cand_upd;

  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign s_axis_tready = !out_valid_q || m_axis_tready;
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {5'd0, out_res_q};
  assign count         = s_axis_tdata[31:16];
  assign wl_dec        = words_left_q - 16'd1;

  always_comb begin
    hdr_idx_d    = hdr_idx_q;
    magic_d      = magic_q;
    words_left_d = words_left_q;
    pos_d        = pos_q;
    cand_d       = cand_q;
    match_d      = match_q;
    stopped_d    = stopped_q;
    long_enough  = 1'b0;
    cand_upd     = cand_q;
    out_valid_d  = out_valid_q && !m_axis_tready;
    out_res_d    = out_res_q;

    if (in_acc) begin
      if (hdr_idx_q < HeaderWords) begin
        if (hdr_idx_q == 3'd0) begin
          magic_d = (s_axis_tdata == SpvMagic);
        end
        hdr_idx_d = hdr_idx_q + 3'd1;
      end else begin
        long_enough = 1'b1;
        if (!stopped_q && magic_q) begin
          if (words_left_q == 16'd0) begin
            if (count == 16'd0) begin
              stopped_d = 1'b1;
            end else begin
              words_left_d = count - 16'd1;
              pos_d        = 3'd1;
              cand_d       = (s_axis_tdata[15:0] == OpExtInstImport) &&
                             (count >= MinImportCount);
            end
          end else begin
            if (cand_q && pos_q >= 3'd2 && pos_q <= 3'd4 &&
                s_axis_tdata != expected_name_word(pos_q)) begin
              cand_upd = 1'b0;
            end
            cand_d = cand_upd;
            if (pos_q < PosSaturate) begin
              pos_d = pos_q + 3'd1;
            end
            words_left_d = wl_dec;
            if (wl_dec == 16'd0 && cand_upd) begin
              match_d   = 1'b1;
              stopped_d = 1'b1;
            end
          end
        end
      end

      if (s_axis_tlast) begin
        out_valid_d = 1'b1;
        if (!long_enough || !magic_d) begin
          out_res_d.status         = STATUS_NOT_SPIRV;
          out_res_d.uses_extension = 1'b0;
        end else begin
          out_res_d.uses_extension = match_d;
          out_res_d.status = (match_d && !ext_sup_q) ? STATUS_NEEDS_EXT : STATUS_ACCEPTED;
        end
        hdr_idx_d    = '0;
        magic_d      = 1'b0;
        words_left_d = '0;
        pos_d        = '0;
        cand_d       = 1'b0;
        match_d      = 1'b0;
        stopped_d    = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ext_sup_q    <= 1'b0;
      hdr_idx_q    <= '0;
      magic_q      <= 1'b0;
      words_left_q <= '0;
      pos_q        <= '0;
      cand_q       <= 1'b0;
      match_q      <= 1'b0;
      stopped_q    <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        ext_sup_q <= cfg_wdata_i;
      end
      hdr_idx_q    <= hdr_idx_d;
      magic_q      <= magic_d;
      words_left_q <= words_left_d;
      pos_q        <= pos_d;
      cand_q       <= cand_d;
      match_q      <= match_d;
      stopped_q    <= stopped_d;
      out_valid_q  <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_res_q <= out_res_d;
  end

endmodule

/* rtl/spvimp_checker.sv */
// ----------------------------------------------------------------------------
// spirv extension import scanner checker
// port-level checks on the scanner result and input channels, bound to the core
// ----------------------------------------------------------------------------
`include "spirv_extension_import_scanner_core_defines.svh"

module spvimp_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        s_axis_tlast,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [7:0]  m_axis_tdata
);
  import spvimp_pkg::*;

  // stalled result holds
  `SPVIMP_ASSERT(a_out_hold, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata), "result changed while stalled")

  // a result comes only from a last word or a held result
  `SPVIMP_ASSERT(a_out_source, m_axis_tvalid |-> $past(s_axis_tvalid && s_axis_tready && s_axis_tlast) || $past(m_axis_tvalid && !m_axis_tready), "result without last word")

  // not spir-v never reports an import, unsupported always does
  `SPVIMP_ASSERT(a_status_uses, m_axis_tvalid |-> (m_axis_tdata[1:0] != STATUS_NOT_SPIRV || !m_axis_tdata[2]) && (m_axis_tdata[1:0] != STATUS_NEEDS_EXT || m_axis_tdata[2]), "status and import flag disagree")

  // an empty output register never blocks the input
  `SPVIMP_ASSERT_ALWAYS(a_ready_free, !m_axis_tvalid |-> s_axis_tready, "input blocked with empty output")

endmodule

bind spirv_extension_import_scanner_core spvimp_checker u_spvimp_checker (.*);
